>>> rtl/core/tpg_pkg.sv
// shared constants, phase codes and register map of the trapezoid pulse generator
package tpg_pkg;

	localparam int TIME_BITS_DEF  = 48;
	localparam int LEVEL_BITS_DEF = 32;
	localparam int PHASE_BITS     = 3;
	localparam int CFG_DATA_BITS  = 64;
	localparam int CFG_ADDR_BITS  = 6;
	localparam int MUL_CHUNK      = 16;

	typedef enum logic [PHASE_BITS-1:0] {
		PH_DELAY = 3'd0,
		PH_RISE  = 3'd1,
		PH_HIGH  = 3'd2,
		PH_FALL  = 3'd3,
		PH_LOW   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		REG_INITIAL = 3'd0,
		REG_PULSE   = 3'd1,
		REG_DELAY   = 3'd2,
		REG_RISE    = 3'd3,
		REG_FALL    = 3'd4,
		REG_WIDTH   = 3'd5,
		REG_PERIOD  = 3'd6,
		REG_NONE    = 3'd7
	} reg_idx_t;

endpackage

>>> rtl/core/tpg_div.sv
// pipelined restoring divider, one quotient bit per stage
module tpg_div #(
	parameter int NB = 8,
	parameter int RB = 8,
	parameter int SB = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [RB-1:0] rem_in,
	input  logic [NB-1:0] bits_in,
	input  logic [RB-1:0] dvs_in,
	input  logic [SB-1:0] side_in,
	output logic          out_valid,
	output logic [RB-1:0] rem_out,
	output logic [NB-1:0] quo_out,
	output logic [SB-1:0] side_out
);
	logic          v_s    [0:NB];
	logic [RB-1:0] rem_s  [0:NB];
	logic [NB-1:0] bits_s [0:NB];
	logic [NB-1:0] quo_s  [0:NB];
	logic [RB-1:0] dvs_s  [0:NB];
	logic [SB-1:0] side_s [0:NB];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = rem_in;
	assign bits_s[0] = bits_in;
	assign quo_s[0]  = '0;
	assign dvs_s[0]  = dvs_in;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < NB; i++) begin : g_step
		logic [RB:0] r2;
		logic        ge;

		// shift in the next dividend bit, subtract when it fits
		assign r2 = {rem_s[i], bits_s[i][NB-1]};
		assign ge = (r2 >= {1'b0, dvs_s[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? RB'(r2 - {1'b0, dvs_s[i]}) : r2[RB-1:0];
				bits_s[i+1] <= bits_s[i] << 1;
				quo_s[i+1]  <= (quo_s[i] << 1) | NB'(ge);
				dvs_s[i+1]  <= dvs_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = v_s[NB];
	assign rem_out   = rem_s[NB];
	assign quo_out   = quo_s[NB];
	assign side_out  = side_s[NB];

endmodule

>>> rtl/core/tpg_classify.sv
// phase decision and saturated breakpoint sums over four stages
module tpg_classify #(
	parameter int TIME_BITS  = tpg_pkg::TIME_BITS_DEF,
	parameter int LEVEL_BITS = tpg_pkg::LEVEL_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [TIME_BITS-1:0]   t,
	input  logic [TIME_BITS-1:0]   rel,
	input  logic                   in_delay,
	input  logic [LEVEL_BITS-1:0]  initial_level,
	input  logic [LEVEL_BITS-1:0]  pulse_level,
	input  logic [TIME_BITS-1:0]   start_delay,
	input  logic [TIME_BITS-1:0]   rise_time,
	input  logic [TIME_BITS-1:0]   fall_time,
	input  logic [TIME_BITS-1:0]   high_width,
	input  logic [TIME_BITS-1:0]   repeat_period,
	output logic                   out_valid,
	output tpg_pkg::phase_t        phase,
	output logic [TIME_BITS-1:0]   brk,
	output logic [TIME_BITS-1:0]   num,
	output logic [TIME_BITS-1:0]   den,
	output logic [LEVEL_BITS-1:0]  from,
	output logic [LEVEL_BITS-1:0]  mag,
	output logic                   neg
);
	import tpg_pkg::*;

	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
		input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
	endfunction

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [TIME_BITS-1:0] base_s1, rel_s1, d1_s1;
	logic                 ltr_s1, dly_s1;
	logic [TIME_BITS-1:0] base_s2, rel_s2, d2_s2, er_s2;
	logic                 ltr_s2, dly_s2, hiok_s2, eq_s2;
	logic [TIME_BITS-1:0] rel_s3, d2_s3, er_s3, eh_s3, ep_s3;
	logic                 ltr_s3, dly_s3, hiok_s3, eq_s3, ltf_s3;
	logic                 wz;

	phase_t                ph_c;
	logic [TIME_BITS-1:0]  ef_c, brk_c, num_c, den_c;
	logic [LEVEL_BITS-1:0] from_c, to_c;
	logic [LEVEL_BITS:0]   diff_c, ndiff_c;

	phase_t                phase_s4;
	logic [TIME_BITS-1:0]  brk_s4, num_s4, den_s4;
	logic [LEVEL_BITS-1:0] from_s4, mag_s4;
	logic                  neg_s4;

	assign wz = (high_width == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1 <= t - rel;
			rel_s1  <= rel;
			d1_s1   <= rel - rise_time;
			ltr_s1  <= (rel < rise_time);
			dly_s1  <= in_delay;

			base_s2 <= base_s1;
			rel_s2  <= rel_s1;
			d2_s2   <= d1_s1 - high_width;
			er_s2   <= sat_add(base_s1, rise_time);
			ltr_s2  <= ltr_s1;
			dly_s2  <= dly_s1;
			hiok_s2 <= wz || (d1_s1 <= high_width);
			eq_s2   <= !wz && (d1_s1 == high_width);

			rel_s3  <= rel_s2;
			d2_s3   <= d2_s2;
			er_s3   <= er_s2;
			eh_s3   <= wz ? '1 : sat_add(er_s2, high_width);
			ep_s3   <= (repeat_period == '0) ? '1 : sat_add(base_s2, repeat_period);
			ltr_s3  <= ltr_s2;
			dly_s3  <= dly_s2;
			hiok_s3 <= hiok_s2;
			eq_s3   <= eq_s2;
			ltf_s3  <= (d2_s2 < fall_time);
		end
	end

	always_comb begin
		ef_c   = wz ? '1 : sat_add(eh_s3, fall_time);
		num_c  = '0;
		den_c  = TIME_BITS'(1);
		from_c = initial_level;
		to_c   = initial_level;
		if (dly_s3) begin
			ph_c  = PH_DELAY;
			brk_c = start_delay;
		end else if (ltr_s3) begin
			ph_c  = PH_RISE;
			brk_c = er_s3;
			num_c = rel_s3;
			den_c = rise_time;
			to_c  = pulse_level;
		end else if (hiok_s3) begin
			ph_c   = PH_HIGH;
			brk_c  = eq_s3 ? ef_c : eh_s3;
			from_c = pulse_level;
			to_c   = pulse_level;
		end else if (ltf_s3) begin
			ph_c   = PH_FALL;
			brk_c  = ef_c;
			num_c  = d2_s3;
			den_c  = fall_time;
			from_c = pulse_level;
		end else begin
			ph_c  = PH_LOW;
			brk_c = ep_s3;
		end
		diff_c  = {to_c[LEVEL_BITS-1], to_c} - {from_c[LEVEL_BITS-1], from_c};
		ndiff_c = -diff_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s4 <= ph_c;
			brk_s4   <= brk_c;
			num_s4   <= num_c;
			den_s4   <= den_c;
			from_s4  <= from_c;
			neg_s4   <= diff_c[LEVEL_BITS];
			mag_s4   <= diff_c[LEVEL_BITS] ? ndiff_c[LEVEL_BITS-1:0] : diff_c[LEVEL_BITS-1:0];
		end
	end

	assign out_valid = v_s4;
	assign phase     = phase_s4;
	assign brk       = brk_s4;
	assign num       = num_s4;
	assign den       = den_s4;
	assign from      = from_s4;
	assign mag       = mag_s4;
	assign neg       = neg_s4;

endmodule

>>> rtl/core/tpg_interp.sv
// edge interpolation: chunked multiply, pipelined divide, final offset
module tpg_interp #(
	parameter int TIME_BITS  = tpg_pkg::TIME_BITS_DEF,
	parameter int LEVEL_BITS = tpg_pkg::LEVEL_BITS_DEF,
	parameter int SB         = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [TIME_BITS-1:0]  num,
	input  logic [TIME_BITS-1:0]  den,
	input  logic [LEVEL_BITS-1:0] from,
	input  logic [LEVEL_BITS-1:0] mag,
	input  logic                  neg,
	input  logic [SB-1:0]         side_in,
	output logic                  out_valid,
	output logic [LEVEL_BITS-1:0] level,
	output logic [SB-1:0]         side_out
);
	import tpg_pkg::*;

	localparam int NC   = (TIME_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int NUMW = NC * MUL_CHUNK;
	localparam int PW   = TIME_BITS + LEVEL_BITS;
	localparam int DSB  = SB + LEVEL_BITS + 1;

	logic                  mv_s   [0:NC];
	logic [PW-1:0]         acc_s  [0:NC];
	logic [NUMW-1:0]       num_s  [0:NC];
	logic [LEVEL_BITS-1:0] mag_s  [0:NC];
	logic [TIME_BITS-1:0]  den_s  [0:NC];
	logic [DSB-1:0]        dside_s[0:NC];

	logic                  dv;
	logic [LEVEL_BITS-1:0] dquo;
	logic [DSB-1:0]        dside;
	logic [LEVEL_BITS-1:0] dfrom;
	logic                  dneg;
	logic [LEVEL_BITS:0]   lvl_c;

	logic                  v_s1;
	logic [LEVEL_BITS-1:0] level_s1;
	logic [SB-1:0]         side_s1;

	assign mv_s[0]    = in_valid;
	assign acc_s[0]   = '0;
	assign num_s[0]   = NUMW'(num);
	assign mag_s[0]   = mag;
	assign den_s[0]   = den;
	assign dside_s[0] = {side_in, from, neg};

	// one partial product of a num chunk and the magnitude per stage
	for (genvar k = 0; k < NC; k++) begin : g_mul
		logic [MUL_CHUNK+LEVEL_BITS-1:0] pp;

		assign pp = num_s[k][k*MUL_CHUNK +: MUL_CHUNK] * mag_s[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mv_s[k+1] <= 1'b0;
			end else if (en) begin
				mv_s[k+1] <= mv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k+1]   <= acc_s[k] + (PW'(pp) << (k * MUL_CHUNK));
				num_s[k+1]   <= num_s[k];
				mag_s[k+1]   <= mag_s[k];
				den_s[k+1]   <= den_s[k];
				dside_s[k+1] <= dside_s[k];
			end
		end
	end

	// quotient is below the magnitude, so the high product bits are below den
	tpg_div #(
		.NB (LEVEL_BITS),
		.RB (TIME_BITS),
		.SB (DSB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (mv_s[NC]),
		.rem_in   (acc_s[NC][PW-1:LEVEL_BITS]),
		.bits_in  (acc_s[NC][LEVEL_BITS-1:0]),
		.dvs_in   (den_s[NC]),
		.side_in  (dside_s[NC]),
		.out_valid(dv),
		.rem_out  (),
		.quo_out  (dquo),
		.side_out (dside)
	);

	assign dfrom = dside[LEVEL_BITS:1];
	assign dneg  = dside[0];
	assign lvl_c = dneg ? ({dfrom[LEVEL_BITS-1], dfrom} - {1'b0, dquo})
	                    : ({dfrom[LEVEL_BITS-1], dfrom} + {1'b0, dquo});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_s1 <= lvl_c[LEVEL_BITS-1:0];
			side_s1  <= dside[DSB-1:LEVEL_BITS+1];
		end
	end

	assign out_valid = v_s1;
	assign level     = level_s1;
	assign side_out  = side_s1;

endmodule

>>> rtl/core/trapezoid_pulse_generator.sv
// Periodic trapezoid pulse generator. Fully pipelined: one time stamp is taken
// every clock while s_tready is high. Each time stamp passes an input register, the
// bit-per-stage modulo of the time past the start delay by the period, the classify
// stages, and the chunked multiply, bit-per-stage divide and offset of the edge
// interpolation. A two-entry output buffer lets input keep flowing while one
// result waits; s_tready drops only when both entries are full. Registers are
// 64-bit APB words at byte address 8*index and must be written while idle.
module trapezoid_pulse_generator #(
	parameter int TIME_BITS  = tpg_pkg::TIME_BITS_DEF,
	parameter int LEVEL_BITS = tpg_pkg::LEVEL_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// now_ticks
	input  logic [((TIME_BITS+7)/8)*8-1:0]            s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// level_out, next_break, phase_code
	output logic [((LEVEL_BITS+TIME_BITS+tpg_pkg::PHASE_BITS+7)/8)*8-1:0] m_tdata,
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [tpg_pkg::CFG_ADDR_BITS-1:0]         paddr,
	input  logic [tpg_pkg::CFG_DATA_BITS-1:0]         pwdata,
	output logic [tpg_pkg::CFG_DATA_BITS-1:0]         prdata,
	output logic                                      pready
);
	import tpg_pkg::*;

	localparam int OUT_RAW = LEVEL_BITS + TIME_BITS + PHASE_BITS;
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
	localparam int MSB     = 2 * TIME_BITS + 1;
	localparam int RSB     = TIME_BITS + PHASE_BITS;

	logic [LEVEL_BITS-1:0] iv_q, pv_q;
	logic [TIME_BITS-1:0]  sd_q, rise_q, fall_q, width_q, period_q;
	reg_idx_t              ridx;
	logic                  wr;

	logic                  en;
	logic                  v_s1, dly_s1;
	logic [TIME_BITS-1:0]  t_s1, rel0_s1;

	logic                  mv;
	logic [TIME_BITS-1:0]  mrem;
	logic [MSB-1:0]        mside;
	logic [TIME_BITS-1:0]  mt, mrel0, rel;
	logic                  mdly;

	logic                  cv, cneg;
	phase_t                cphase;
	logic [TIME_BITS-1:0]  cbrk, cnum, cden;
	logic [LEVEL_BITS-1:0] cfrom, cmag;

	logic                  iv_valid;
	logic [LEVEL_BITS-1:0] ilevel;
	logic [RSB-1:0]        iside;

	logic                  o_valid_q, sk_valid_q;
	logic [OUT_RAW-1:0]    o_data_q, sk_data_q, res;

	// configuration port
	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[CFG_ADDR_BITS-1:3]);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_q     <= '0;
			pv_q     <= '0;
			sd_q     <= '0;
			rise_q   <= '0;
			fall_q   <= '0;
			width_q  <= '0;
			period_q <= '0;
		end else if (wr) begin
			case (ridx)
				REG_INITIAL: iv_q     <= pwdata[LEVEL_BITS-1:0];
				REG_PULSE:   pv_q     <= pwdata[LEVEL_BITS-1:0];
				REG_DELAY:   sd_q     <= pwdata[TIME_BITS-1:0];
				REG_RISE:    rise_q   <= pwdata[TIME_BITS-1:0];
				REG_FALL:    fall_q   <= pwdata[TIME_BITS-1:0];
				REG_WIDTH:   width_q  <= pwdata[TIME_BITS-1:0];
				REG_PERIOD:  period_q <= pwdata[TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_INITIAL: prdata = CFG_DATA_BITS'($signed(iv_q));
			REG_PULSE:   prdata = CFG_DATA_BITS'($signed(pv_q));
			REG_DELAY:   prdata = CFG_DATA_BITS'(sd_q);
			REG_RISE:    prdata = CFG_DATA_BITS'(rise_q);
			REG_FALL:    prdata = CFG_DATA_BITS'(fall_q);
			REG_WIDTH:   prdata = CFG_DATA_BITS'(width_q);
			REG_PERIOD:  prdata = CFG_DATA_BITS'(period_q);
			default:     prdata = '0;
		endcase
	end

	// whole pipeline moves while the spare output entry is free
	assign en       = !sk_valid_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= s_tdata[TIME_BITS-1:0];
			dly_s1  <= (s_tdata[TIME_BITS-1:0] <= sd_q);
			rel0_s1 <= s_tdata[TIME_BITS-1:0] - sd_q;
		end
	end

	tpg_div #(
		.NB (TIME_BITS),
		.RB (TIME_BITS),
		.SB (MSB)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.rem_in   ('0),
		.bits_in  (rel0_s1),
		.dvs_in   (period_q),
		.side_in  ({dly_s1, rel0_s1, t_s1}),
		.out_valid(mv),
		.rem_out  (mrem),
		.quo_out  (),
		.side_out (mside)
	);

	assign mt    = mside[TIME_BITS-1:0];
	assign mrel0 = mside[2*TIME_BITS-1:TIME_BITS];
	assign mdly  = mside[MSB-1];
	assign rel   = (period_q != '0) ? mrem : mrel0;

	tpg_classify #(
		.TIME_BITS (TIME_BITS),
		.LEVEL_BITS(LEVEL_BITS)
	) u_cls (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (mv),
		.t            (mt),
		.rel          (rel),
		.in_delay     (mdly),
		.initial_level(iv_q),
		.pulse_level  (pv_q),
		.start_delay  (sd_q),
		.rise_time    (rise_q),
		.fall_time    (fall_q),
		.high_width   (width_q),
		.repeat_period(period_q),
		.out_valid    (cv),
		.phase        (cphase),
		.brk          (cbrk),
		.num          (cnum),
		.den          (cden),
		.from         (cfrom),
		.mag          (cmag),
		.neg          (cneg)
	);

	tpg_interp #(
		.TIME_BITS (TIME_BITS),
		.LEVEL_BITS(LEVEL_BITS),
		.SB        (RSB)
	) u_int (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (cv),
		.num      (cnum),
		.den      (cden),
		.from     (cfrom),
		.mag      (cmag),
		.neg      (cneg),
		.side_in  ({cphase, cbrk}),
		.out_valid(iv_valid),
		.level    (ilevel),
		.side_out (iside)
	);

	assign res = {iside, ilevel};

	// output register plus one spare entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q  <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (sk_valid_q) begin
			if (m_tready) begin
				sk_valid_q <= 1'b0;
			end
		end else if (!o_valid_q || m_tready) begin
			o_valid_q <= iv_valid;
		end else if (iv_valid) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_valid_q) begin
			if (m_tready) begin
				o_data_q <= sk_data_q;
			end
		end else if (!o_valid_q || m_tready) begin
			o_data_q <= res;
		end else begin
			sk_data_q <= res;
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = OUT_W'(o_data_q);

endmodule

>>> rtl/core/tpg_checker.sv
// port-level checks for the trapezoid pulse generator, bound to the top level
module tpg_checker #(
	parameter int TIME_BITS  = tpg_pkg::TIME_BITS_DEF,
	parameter int LEVEL_BITS = tpg_pkg::LEVEL_BITS_DEF
) (
	input logic                                      clk,
	input logic                                      arst_n,
	input logic                                      s_tready,
	input logic                                      m_tvalid,
	input logic                                      m_tready,
	input logic [((LEVEL_BITS+TIME_BITS+tpg_pkg::PHASE_BITS+7)/8)*8-1:0] m_tdata,
	input logic                                      pready
);
	import tpg_pkg::*;

	localparam int PH_LSB = LEVEL_BITS + TIME_BITS;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[PH_LSB +: PHASE_BITS] <= PH_LOW))
		else $error("phase code out of range");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

endmodule

bind trapezoid_pulse_generator tpg_checker #(
	.TIME_BITS (TIME_BITS),
	.LEVEL_BITS(LEVEL_BITS)
) u_tpg_checker (.*);
